>>> design/lfd_pkg.sv
// Shared constants and types for the length-prefixed frame deframer.
// No dependencies; compiled first.
`default_nettype none

package lfd_pkg;

    // Field widths of the byte and frame channels
    localparam int LFD_BYTE_W  = 8;
    localparam int LFD_WORD_W  = 32;
    localparam int LFD_TLEN_W  = 7;
    localparam int LFD_CFG_W   = 7;
    localparam int LFD_HLEN_W  = 16;

    // Message header size in bytes
    localparam int LFD_HDR_BYTES = 4;

    // Default payload capacity and register reset value
    localparam int              LFD_MAX_PAYLOAD = 64;
    localparam logic [LFD_CFG_W-1:0] LFD_CFG_RESET = 7'd64;

    // Stream status codes
    localparam logic LFD_STATUS_OK      = 1'b0;
    localparam logic LFD_STATUS_CORRUPT = 1'b1;

    // Store port controls
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } lfd_mem_ctl_t;

endpackage : lfd_pkg

`default_nettype wire

>>> design/lfd_if.sv
// Valid/ready channel interfaces: stream bytes in, frame words out.
// Depends on lfd_pkg for field widths.
`default_nettype none

interface lfd_byte_if;
    import lfd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [LFD_BYTE_W-1:0] data_byte;
    logic                  new_connection;

    modport source (output valid, output data_byte, output new_connection, input ready);
    modport sink   (input valid, input data_byte, input new_connection, output ready);
endinterface : lfd_byte_if

interface lfd_frame_if;
    import lfd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [LFD_WORD_W-1:0] frame_word;
    logic [LFD_TLEN_W-1:0] frame_total_len;
    logic                  last_word;
    logic                  stream_status;

    modport source (output valid, output frame_word, output frame_total_len,
                    output last_word, output stream_status, input ready);
    modport sink   (input valid, input frame_word, input frame_total_len,
                    input last_word, input stream_status, output ready);
endinterface : lfd_frame_if

`default_nettype wire

>>> design/lfd_store.sv
// Message word store: one write port, one read port, registered read data.
// Depends on lfd_pkg for the port control struct.
`default_nettype none

module lfd_store #(
    parameter int DEPTH = 17,
    parameter int AW    = 5
) (
    input  wire                            clk,
    input  wire lfd_pkg::lfd_mem_ctl_t     ctl,
    input  wire [AW-1:0]                   waddr,
    input  wire [lfd_pkg::LFD_WORD_W-1:0]  wdata,
    input  wire [AW-1:0]                   raddr,
    output logic [lfd_pkg::LFD_WORD_W-1:0] rdata
);
    import lfd_pkg::*;

    logic [LFD_WORD_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : lfd_store

`default_nettype wire

>>> design/lfd_ctrl.sv
// Byte collection, header check and readout sequencer with output register.
// Depends on lfd_pkg and the channel interfaces in lfd_if.sv.
`default_nettype none

module lfd_ctrl #(
    parameter int MAX_PAYLOAD = 64,
    parameter int AW          = 5,
    parameter int CNT_W       = 7,
    parameter int LEN_W       = 7
) (
    input  wire                            clk,
    input  wire                            rst_n,
    lfd_byte_if.sink                       byte_in,
    lfd_frame_if.source                    frame_out,
    input  wire [lfd_pkg::LFD_CFG_W-1:0]   max_len,
    output lfd_pkg::lfd_mem_ctl_t          mem_ctl,
    output logic [AW-1:0]                  mem_waddr,
    output logic [lfd_pkg::LFD_WORD_W-1:0] mem_wdata,
    output logic [AW-1:0]                  mem_raddr,
    input  wire [lfd_pkg::LFD_WORD_W-1:0]  mem_rdata
);
    import lfd_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    // Registers
    state_t                state_reg,    state_next;
    logic [CNT_W-1:0]      cnt_reg,      cnt_next;
    logic [LEN_W-1:0]      len_reg,      len_next;
    logic                  broken_reg,   broken_next;
    logic [LFD_WORD_W-1:0] asm_reg,      asm_next;
    logic [AW-1:0]         rd_addr_reg,  rd_addr_next;
    logic [AW-1:0]         last_idx_reg, last_idx_next;
    logic [LFD_TLEN_W-1:0] tot_reg,      tot_next;
    logic                  rd_pend_reg,  rd_pend_next;
    logic                  rd_last_reg,  rd_last_next;
    logic                  ov_reg,       ov_next;
    logic [LFD_WORD_W-1:0] ow_reg,       ow_next;
    logic [LFD_TLEN_W-1:0] ol_reg,       ol_next;
    logic                  olast_reg,    olast_next;
    logic                  ost_reg,      ost_next;

    // Working signals
    logic                  slot_free;
    logic                  in_ready;
    logic                  take;
    logic [CNT_W-1:0]      pos;
    logic [CNT_W-1:0]      pos_inc;
    logic [1:0]            lane;
    logic                  eff_broken;
    logic [LFD_WORD_W-1:0] merged;
    logic [LFD_HLEN_W-1:0] hdr_len;
    logic                  hdr_bad;
    logic [CNT_W-1:0]      total;
    logic                  rd_issue;

    assign slot_free = !ov_reg || frame_out.ready;
    assign in_ready  = (state_reg == ST_IDLE) && !rd_pend_reg && slot_free;
    assign take      = byte_in.valid && in_ready;

    // Position of this byte; a new connection restarts the message
    assign pos        = byte_in.new_connection ? '0 : cnt_reg;
    assign eff_broken = byte_in.new_connection ? 1'b0 : broken_reg;
    assign pos_inc    = pos + CNT_W'(1);
    assign lane       = pos[1:0];
    assign merged     = ((lane == 2'd0) ? '0 : asm_reg)
                        | (LFD_WORD_W'(byte_in.data_byte) << {lane, 3'b000});

    // Header check when the fourth byte arrives; bytes 0 and 1 sit in asm_reg
    assign hdr_len = asm_reg[LFD_HLEN_W-1:0];
    assign hdr_bad = (hdr_len == '0)
                     || (hdr_len > LFD_HLEN_W'(max_len))
                     || (hdr_len > LFD_HLEN_W'(MAX_PAYLOAD));
    assign total   = CNT_W'(len_reg) + CNT_W'(LFD_HDR_BYTES);

    // One store read in flight; issue only when the output slot will be free
    assign rd_issue = (state_reg == ST_EMIT) && !rd_pend_reg && slot_free;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        len_next      = len_reg;
        broken_next   = broken_reg;
        asm_next      = asm_reg;
        rd_addr_next  = rd_addr_reg;
        last_idx_next = last_idx_reg;
        tot_next      = tot_reg;
        rd_pend_next  = 1'b0;
        rd_last_next  = rd_last_reg;
        ov_next       = ov_reg && !frame_out.ready;
        ow_next       = ow_reg;
        ol_next       = ol_reg;
        olast_next    = olast_reg;
        ost_next      = ost_reg;

        mem_ctl.wr_en = 1'b0;
        mem_ctl.rd_en = 1'b0;
        mem_waddr     = AW'(pos >> 2);
        mem_wdata     = merged;
        mem_raddr     = rd_addr_reg;

        // Store data returns: load the output slot
        if (rd_pend_reg)
        begin
            ov_next    = 1'b1;
            ow_next    = mem_rdata;
            ol_next    = tot_reg;
            olast_next = rd_last_reg;
            ost_next   = LFD_STATUS_OK;
        end

        // Incoming byte
        if (take)
        begin
            if (byte_in.new_connection)
            begin
                cnt_next    = '0;
                len_next    = '0;
                broken_next = 1'b0;
            end
            if (!eff_broken)
            begin
                asm_next = merged;
                cnt_next = pos_inc;
                if (lane == 2'd3)
                begin
                    mem_ctl.wr_en = 1'b1;
                end
                if (pos_inc == CNT_W'(LFD_HDR_BYTES))
                begin
                    if (hdr_bad)
                    begin
                        broken_next = 1'b1;
                        cnt_next    = '0;
                        len_next    = '0;
                        ov_next     = 1'b1;
                        ow_next     = '0;
                        ol_next     = '0;
                        olast_next  = 1'b1;
                        ost_next    = LFD_STATUS_CORRUPT;
                    end
                    else
                    begin
                        len_next = LEN_W'(hdr_len);
                    end
                end
                else if ((pos_inc > CNT_W'(LFD_HDR_BYTES)) && (pos_inc == total))
                begin
                    // Message complete: flush the last word and read it all out
                    mem_ctl.wr_en = 1'b1;
                    cnt_next      = '0;
                    len_next      = '0;
                    last_idx_next = AW'(pos >> 2);
                    tot_next      = LFD_TLEN_W'(total);
                    rd_addr_next  = '0;
                    state_next    = ST_EMIT;
                end
            end
        end

        // Readout of stored words
        if (rd_issue)
        begin
            mem_ctl.rd_en = 1'b1;
            rd_pend_next  = 1'b1;
            rd_last_next  = (rd_addr_reg == last_idx_reg);
            if (rd_addr_reg == last_idx_reg)
            begin
                state_next = ST_IDLE;
            end
            else
            begin
                rd_addr_next = rd_addr_reg + AW'(1);
            end
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            len_reg      <= '0;
            broken_reg   <= 1'b0;
            asm_reg      <= '0;
            rd_addr_reg  <= '0;
            last_idx_reg <= '0;
            tot_reg      <= '0;
            rd_pend_reg  <= 1'b0;
            rd_last_reg  <= 1'b0;
            ov_reg       <= 1'b0;
            ow_reg       <= '0;
            ol_reg       <= '0;
            olast_reg    <= 1'b0;
            ost_reg      <= LFD_STATUS_OK;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            len_reg      <= len_next;
            broken_reg   <= broken_next;
            asm_reg      <= asm_next;
            rd_addr_reg  <= rd_addr_next;
            last_idx_reg <= last_idx_next;
            tot_reg      <= tot_next;
            rd_pend_reg  <= rd_pend_next;
            rd_last_reg  <= rd_last_next;
            ov_reg       <= ov_next;
            ow_reg       <= ow_next;
            ol_reg       <= ol_next;
            olast_reg    <= olast_next;
            ost_reg      <= ost_next;
        end
    end

    assign byte_in.ready             = in_ready;
    assign frame_out.valid           = ov_reg;
    assign frame_out.frame_word      = ow_reg;
    assign frame_out.frame_total_len = ol_reg;
    assign frame_out.last_word       = olast_reg;
    assign frame_out.stream_status   = ost_reg;

endmodule : lfd_ctrl

`default_nettype wire

>>> design/length_prefixed_frame_deframer_top.sv
// Top level of the length-prefixed frame deframer: config register, store, control.
// Depends on lfd_pkg, lfd_if.sv, lfd_store and lfd_ctrl.
//
//  channel    dir  handshake       payload
//  byte_in    in   valid/ready     data_byte[7:0], new_connection
//  frame_out  out  valid/ready     frame_word[31:0], frame_total_len[6:0],
//                                  last_word, stream_status
//  cfg        in   cfg_we          cfg_wdata[6:0] (max_payload_len)
//
// A stream byte is taken only when idle, with no store read pending and the
// output slot free. A completed message is read out of the store word by word
// (one read in flight on the read port) before the next byte is taken.
// Reset clears control state only; the store needs no clearing pass.
// A stalled frame_out holds its word; bytes are not taken during readout.
`default_nettype none

module length_prefixed_frame_deframer_top #(
    parameter int MAX_PAYLOAD = lfd_pkg::LFD_MAX_PAYLOAD
) (
    input  wire                          clk,
    input  wire                          rst_n,
    lfd_byte_if.sink                     byte_in,
    lfd_frame_if.source                  frame_out,
    input  wire                          cfg_we,
    input  wire [lfd_pkg::LFD_CFG_W-1:0] cfg_wdata
);
    import lfd_pkg::*;

    localparam int WORDS = (MAX_PAYLOAD + LFD_HDR_BYTES + 3) / 4;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNT_W = $clog2(MAX_PAYLOAD + LFD_HDR_BYTES + 1);
    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

    logic [LFD_CFG_W-1:0]  max_len_reg;
    lfd_mem_ctl_t          mem_ctl;
    logic [AW-1:0]         mem_waddr;
    logic [AW-1:0]         mem_raddr;
    logic [LFD_WORD_W-1:0] mem_wdata;
    logic [LFD_WORD_W-1:0] mem_rdata;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= LFD_CFG_RESET;
        end
        else if (cfg_we)
        begin
            max_len_reg <= cfg_wdata;
        end
    end

    lfd_store #(
        .DEPTH (WORDS),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .ctl   (mem_ctl),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lfd_ctrl #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .AW          (AW),
        .CNT_W       (CNT_W),
        .LEN_W       (LEN_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in),
        .frame_out (frame_out),
        .max_len   (max_len_reg),
        .mem_ctl   (mem_ctl),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Store is never written and read in the same cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_ctl.wr_en && mem_ctl.rd_en))
        else $error("store read and write in the same cycle");

    // No byte request is taken while a readout is in progress
    a_no_take_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_in.valid && byte_in.ready) |-> !mem_ctl.rd_en)
        else $error("byte request taken during readout");

    // Every store read lands in the output slot: data back next cycle, slot after that
    a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.rd_en |-> ##2 (frame_out.valid && frame_out.stream_status == LFD_STATUS_OK))
        else $error("store read data not presented");

    // An error result is a bare last word with zero data and length
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_out.valid && frame_out.stream_status == LFD_STATUS_CORRUPT)
        |-> (frame_out.last_word && frame_out.frame_word == '0
             && frame_out.frame_total_len == '0))
        else $error("malformed error result");

endmodule : length_prefixed_frame_deframer_top

`default_nettype wire
